@@ hdl/cia_pkg.sv @@
// ----------------------------------------------------------------------------
// cia_pkg: shared types and codes
// Opcodes, status codes and the control word that travels along the chain.
// ----------------------------------------------------------------------------
package cia_pkg;

  localparam int FIELD_W = 64;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_REM = 4'd4;
  localparam logic [3:0] OP_EQ  = 4'd5;
  localparam logic [3:0] OP_NE  = 4'd6;
  localparam logic [3:0] OP_GT  = 4'd7;
  localparam logic [3:0] OP_GE  = 4'd8;
  localparam logic [3:0] OP_LT  = 4'd9;
  localparam logic [3:0] OP_LE  = 4'd10;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVER  = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;

  typedef struct packed {
    logic       valid;
    logic [3:0] op;
    logic       sg;
    logic       na;
    logic       nb;
    logic [1:0] st;
  } ctl_t;

endpackage

@@ hdl/cia_front.sv @@
// ----------------------------------------------------------------------------
// cia_front: operand decode stage
// Takes the operands apart into sign and magnitude, settles add, subtract and
// compare results and the early error cases, and loads the first cell.
// ----------------------------------------------------------------------------
module cia_front import cia_pkg::*; #(
  parameter int W = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic                 sg_mode,
  input  logic [3:0]           op,
  input  logic [FIELD_W-1:0]   lhs,
  input  logic [FIELD_W-1:0]   rhs,
  output ctl_t                 ctl,
  output logic [W-1:0]         p,
  output logic [W-1:0]         q,
  output logic [W-1:0]         mb
);

  logic [W-1:0] a, b, ma, mb_next, sum, dif, ca, cb, p_next, q_next;
  logic         na, nb;
  ctl_t         ctl_next;

  always_comb begin
    a       = lhs[W-1:0];
    b       = rhs[W-1:0];
    na      = sg_mode & a[W-1];
    nb      = sg_mode & b[W-1];
    ma      = na ? (~a + 1'b1) : a;
    mb_next = nb ? (~b + 1'b1) : b;
    sum     = a + b;
    dif     = a - b;
    // sign flip turns a signed compare into an unsigned one
    ca      = sg_mode ? {~a[W-1], a[W-2:0]} : a;
    cb      = sg_mode ? {~b[W-1], b[W-2:0]} : b;

    ctl_next.valid = in_valid;
    ctl_next.op    = op;
    ctl_next.sg    = sg_mode;
    ctl_next.na    = na;
    ctl_next.nb    = nb;
    ctl_next.st    = ST_OK;
    p_next         = '0;
    q_next         = ma;

    case (op)
      OP_ADD: begin
        p_next = sum;
        if (sg_mode) begin
          if (!na && !nb && sum[W-1]) ctl_next.st = ST_OVER;
          else if (na && nb && !sum[W-1]) ctl_next.st = ST_UNDER;
        end else if (sum < a) begin
          ctl_next.st = ST_OVER;
        end
      end
      OP_SUB: begin
        p_next = dif;
        if (sg_mode) begin
          if (!na && nb && dif[W-1]) ctl_next.st = ST_OVER;
          else if (na && !nb && !dif[W-1]) ctl_next.st = ST_UNDER;
        end else if (a < b) begin
          ctl_next.st = ST_UNDER;
        end
      end
      OP_MUL: ;
      OP_DIV: begin
        // divide by zero, and signed minimum over minus one
        if (b == '0) ctl_next.st = ST_OVER;
        else if (sg_mode && a == {1'b1, {(W-1){1'b0}}} && b == '1)
          ctl_next.st = ST_OVER;
      end
      OP_REM: if (b == '0) ctl_next.st = ST_OVER;
      OP_EQ: p_next = W'(a == b);
      OP_NE: p_next = W'(a != b);
      OP_GT: p_next = W'(ca > cb);
      OP_GE: p_next = W'(ca >= cb);
      OP_LT: p_next = W'(ca < cb);
      OP_LE: p_next = W'(ca <= cb);
      default: ctl_next.st = ST_OVER;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (adv) begin
      ctl <= ctl_next;
    end
    if (adv) begin
      p  <= p_next;
      q  <= q_next;
      mb <= mb_next;
    end
  end

endmodule

@@ hdl/cia_cell.sv @@
// ----------------------------------------------------------------------------
// cia_cell: one step of the multiply / divide chain
// Multiply: one shift-add step of the magnitude product, high half in p,
// low half shifting into q. Divide: one restoring step, remainder in p,
// quotient shifting into q. Other ops pass through.
// ----------------------------------------------------------------------------
module cia_cell import cia_pkg::*; #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         adv,
  input  ctl_t         ctl_in,
  input  logic [W-1:0] p_in,
  input  logic [W-1:0] q_in,
  input  logic [W-1:0] mb_in,
  output ctl_t         ctl,
  output logic [W-1:0] p,
  output logic [W-1:0] q,
  output logic [W-1:0] mb
);

  logic [W:0]   msum, trial, tdif;
  logic [W-1:0] p_next, q_next;

  always_comb begin
    msum  = {1'b0, p_in} + {1'b0, (q_in[0] ? mb_in : {W{1'b0}})};
    trial = {p_in, q_in[W-1]};
    tdif  = trial - {1'b0, mb_in};
    p_next = p_in;
    q_next = q_in;
    case (ctl_in.op)
      OP_MUL: begin
        p_next = msum[W:1];
        q_next = {msum[0], q_in[W-1:1]};
      end
      OP_DIV, OP_REM: begin
        if (trial >= {1'b0, mb_in}) begin
          p_next = tdif[W-1:0];
          q_next = {q_in[W-2:0], 1'b1};
        end else begin
          p_next = trial[W-1:0];
          q_next = {q_in[W-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (adv) begin
      ctl <= ctl_in;
    end
    if (adv) begin
      p  <= p_next;
      q  <= q_next;
      mb <= mb_in;
    end
  end

endmodule

@@ hdl/cia_back.sv @@
// ----------------------------------------------------------------------------
// cia_back: result fix-up and output buffer
// Range check and sign restore for multiply and divide, then an output
// register with a skid entry so the chain keeps moving while a result waits.
// ----------------------------------------------------------------------------
module cia_back import cia_pkg::*; #(
  parameter int W = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  ctl_t               ctl_in,
  input  logic [W-1:0]       p_in,
  input  logic [W-1:0]       q_in,
  output logic               adv,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [FIELD_W-1:0] value,
  output logic [1:0]         status
);

  localparam logic [W-1:0] SIGN_BIT = {1'b1, {(W-1){1'b0}}};

  logic [W-1:0]       v, limit;
  logic [1:0]         st;
  logic               neg;
  logic               skid_v;
  logic [FIELD_W-1:0] skid_value;
  logic [1:0]         skid_status;

  always_comb begin
    st    = ctl_in.st;
    v     = p_in;
    neg   = ctl_in.na ^ ctl_in.nb;
    limit = neg ? SIGN_BIT : SIGN_BIT - 1'b1;
    case (ctl_in.op)
      OP_MUL: begin
        if (!ctl_in.sg) begin
          if (p_in != '0) st = ST_OVER;
          v = q_in;
        end else begin
          if (p_in != '0 || q_in > limit) st = neg ? ST_UNDER : ST_OVER;
          v = neg ? (~q_in + 1'b1) : q_in;
        end
      end
      OP_DIV: v = neg ? (~q_in + 1'b1) : q_in;
      OP_REM: v = ctl_in.na ? (~p_in + 1'b1) : p_in;
      default: ;
    endcase
    if (st != ST_OK) v = '0;
  end

  assign adv = !skid_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (skid_v) begin
        value  <= skid_value;
        status <= skid_status;
        skid_v <= 1'b0;
      end else begin
        out_valid <= ctl_in.valid;
        value     <= FIELD_W'(v);
        status    <= st;
      end
    end else if (!out_valid) begin
      out_valid <= ctl_in.valid;
      value     <= FIELD_W'(v);
      status    <= st;
    end else if (ctl_in.valid && !skid_v) begin
      skid_v      <= 1'b1;
      skid_value  <= FIELD_W'(v);
      skid_status <= st;
    end
  end

`ifndef SYNTH
  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_valid) else $error("skid entry held with output empty");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_OVER || status == ST_UNDER))
    else $error("undefined status code");
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (value == '0))
    else $error("non-zero value on error");
`endif

endmodule

@@ hdl/checked_integer_alu_top.sv @@
// ----------------------------------------------------------------------------
// checked_integer_alu_top: overflow-checked integer ALU
// Add, subtract, multiply, divide, remainder and compare with range status.
// ----------------------------------------------------------------------------
// Takes one operation per cycle while the output buffer's skid entry is empty,
// and returns each result after it has passed the front register, the chain
// of WIDTH cells and the output register. Each cell does one shift-add step
// of a multiply or one restoring step of a divide; every operation goes down
// the chain so results leave in order. A two-entry output buffer lets the
// input keep transferring while one result waits. signed_mode is sampled as
// an item is taken in.
module checked_integer_alu_top import cia_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         op,
  input  logic [FIELD_W-1:0] lhs,
  input  logic [FIELD_W-1:0] rhs,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [FIELD_W-1:0] value,
  output logic [1:0]         status
);

  logic             signed_mode;
  logic             adv;
  ctl_t             ctl [WIDTH+1];
  logic [WIDTH-1:0] p   [WIDTH+1];
  logic [WIDTH-1:0] q   [WIDTH+1];
  logic [WIDTH-1:0] mb  [WIDTH+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      signed_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      signed_mode <= cfg_wr_data;
    end
  end

  assign in_ready = adv;

  cia_front #(.W(WIDTH)) u_front (
    .clk, .rst, .adv, .in_valid, .sg_mode(signed_mode), .op, .lhs, .rhs,
    .ctl(ctl[0]), .p(p[0]), .q(q[0]), .mb(mb[0])
  );

  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    cia_cell #(.W(WIDTH)) u_cell (
      .clk, .rst, .adv,
      .ctl_in(ctl[i]), .p_in(p[i]), .q_in(q[i]), .mb_in(mb[i]),
      .ctl(ctl[i+1]), .p(p[i+1]), .q(q[i+1]), .mb(mb[i+1])
    );
  end

  cia_back #(.W(WIDTH)) u_back (
    .clk, .rst, .ctl_in(ctl[WIDTH]), .p_in(p[WIDTH]), .q_in(q[WIDTH]),
    .adv, .out_valid, .out_ready, .value, .status
  );

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: checked integer ALU
// Drives directed and random operations in unsigned and signed mode through
// valid/ready channels with random idling, and checks every result against
// a behavioural predictor of value and status.
// ----------------------------------------------------------------------------
module testbench;
  import cia_pkg::*;

  localparam int W = 64;
  localparam logic [W-1:0] MASK = {W{1'b1}};
  localparam logic [W-1:0] SIGN = {1'b1, {(W-1){1'b0}}};
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [3:0]   op;
    logic [W-1:0] lhs;
    logic [W-1:0] rhs;
  } alu_op_t;

  typedef struct {
    logic [W-1:0] value;
    logic [1:0]   status;
  } alu_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] op = '0;
  logic [FIELD_W-1:0] lhs = '0;
  logic [FIELD_W-1:0] rhs = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [FIELD_W-1:0] value;
  logic [1:0] status;

  checked_integer_alu_top #(.WIDTH(W)) uut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .lhs(lhs), .rhs(rhs),
    .out_valid(out_valid), .out_ready(out_ready), .value(value), .status(status)
  );

  always #5 clk = ~clk;

  alu_op_t  pending_ops[$];
  alu_res_t expected_res[$];
  logic     mode_signed = 1'b0;
  logic     in_done = 1'b0;
  int       errors = 0;
  int       checked = 0;
  int       sent = 0;
  int       cycles = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;

  function automatic logic [W-1:0] neg_of(logic [W-1:0] x, bit n);
    return n ? (~x + 1'b1) : x;
  endfunction

  function automatic alu_res_t compute_alu(alu_op_t t, logic sg);
    alu_res_t r;
    logic [W-1:0] a, b, v, ma, mb, q, limit;
    logic [2*W-1:0] prod;
    bit na, nb, neg;
    logic [W:0] ca, cb;
    logic [1:0] st;
    a = t.lhs; b = t.rhs;
    na = sg && a[W-1];
    nb = sg && b[W-1];
    ma = neg_of(a, na);
    mb = neg_of(b, nb);
    ca = {1'b0, sg ? (a ^ SIGN) : a};
    cb = {1'b0, sg ? (b ^ SIGN) : b};
    v = '0;
    st = ST_OK;
    case (t.op)
      OP_ADD: begin
        v = a + b;
        if (sg) begin
          if (!na && !nb && v[W-1]) st = ST_OVER;
          else if (na && nb && !v[W-1]) st = ST_UNDER;
        end else if (v < a) st = ST_OVER;
      end
      OP_SUB: begin
        v = a - b;
        if (sg) begin
          if (!na && nb && v[W-1]) st = ST_OVER;
          else if (na && !nb && !v[W-1]) st = ST_UNDER;
        end else if (a < b) st = ST_UNDER;
      end
      OP_MUL: begin
        prod = {{W{1'b0}}, ma} * {{W{1'b0}}, mb};
        neg = (na != nb);
        if (!sg) begin
          if (prod[2*W-1:W] != 0) st = ST_OVER;
          v = prod[W-1:0];
        end else begin
          limit = neg ? SIGN : SIGN - 1'b1;
          if (prod[2*W-1:W] != 0 || prod[W-1:0] > limit) st = neg ? ST_UNDER : ST_OVER;
          v = neg_of(prod[W-1:0], neg);
        end
      end
      OP_DIV: begin
        if (b == 0 || (sg && a == SIGN && b == MASK)) st = ST_OVER;
        else begin
          q = ma / mb;
          v = neg_of(q, na != nb);
        end
      end
      OP_REM: begin
        if (b == 0) st = ST_OVER;
        else begin
          q = ma % mb;
          v = neg_of(q, na);
        end
      end
      OP_EQ: v = W'(a == b);
      OP_NE: v = W'(a != b);
      OP_GT: v = W'(ca > cb);
      OP_GE: v = W'(ca >= cb);
      OP_LT: v = W'(ca < cb);
      OP_LE: v = W'(ca <= cb);
      default: st = ST_OVER;
    endcase
    if (st != ST_OK) v = '0;
    r.value = v;
    r.status = st;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h (result %0d)", what, got, want, checked);
  endtask

  // driver: inputs change on the falling edge
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_done) begin
        // hold until the transfer
      end else if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        op  <= pending_ops[0].op;
        lhs <= pending_ops[0].lhs;
        rhs <= pending_ops[0].rhs;
        expected_res.push_back(compute_alu(pending_ops[0], mode_signed));
        void'(pending_ops.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles++;
    in_done <= in_valid && in_ready;
    if (in_valid && in_ready) sent++;
    if (!rst && out_valid && out_ready) begin
      if (expected_res.size() == 0) begin
        report_mismatch("unexpected result", value, '0);
      end else begin
        if (value !== expected_res[0].value)
          report_mismatch("value", value, expected_res[0].value);
        if (status !== expected_res[0].status)
          report_mismatch("status", W'(status), W'(expected_res[0].status));
        void'(expected_res.pop_front());
      end
      checked++;
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [W-1:0] rand_operand();
    logic [W-1:0] x;
    x = {$urandom, $urandom};
    case ($urandom_range(7))
      0: x = '0;
      1: x = MASK;
      2: x = SIGN;
      3: x = SIGN - 1'b1;
      4: x = W'($urandom_range(20)) - W'(10);
      5: x = x >> $urandom_range(W-1);
      default: ;
    endcase
    return x;
  endfunction

  task automatic add_op(logic [3:0] o, logic [W-1:0] a, logic [W-1:0] b);
    alu_op_t t;
    t.op = o; t.lhs = a; t.rhs = b;
    pending_ops.push_back(t);
  endtask

  task automatic drain_and_set(logic sg);
    while (pending_ops.size() > 0 || expected_res.size() > 0 || in_valid)
      @(posedge clk);
    repeat (W + 10) @(posedge clk);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= sg;
    mode_signed = sg;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int ph;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed, unsigned first then signed
    for (int m = 0; m < 2; m++) begin
      drain_and_set(m[0]);
      for (int o = 0; o < 16; o++) add_op(o[3:0], SIGN, MASK);
      add_op(OP_ADD, MASK, W'(1));
      add_op(OP_SUB, W'(0), W'(1));
      add_op(OP_MUL, SIGN, W'(2));
      add_op(OP_MUL, MASK, MASK);
      add_op(OP_DIV, W'(5), W'(0));
      add_op(OP_REM, SIGN, MASK);
      add_op(OP_REM, MASK, W'(0));
      add_op(OP_ADD, SIGN, SIGN);
      add_op(OP_SUB, SIGN - 1'b1, MASK);
    end
    // random, four idling phases per mode
    for (ph = 0; ph < 8; ph++) begin
      drain_and_set(ph[0]);
      case (ph / 2)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      for (int i = 0; i < 125; i++)
        add_op(($urandom_range(15) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(10)),
               rand_operand(), rand_operand());
    end
    drain_and_set(1'b0);
    $display("ran %0d operations, %0d results checked in both modes", sent, checked);
    $display("idling phases: none, sender, receiver, both");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
